// File: hdl/sprite_row_nibble_blitter_assert.svh
// Assertion macros for the sprite row blitter.
`ifndef SPRITE_ROW_NIBBLE_BLITTER_ASSERT_SVH
`define SPRITE_ROW_NIBBLE_BLITTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SRNB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srnb check failed");

// Next-cycle implication, disabled in reset.
`define SRNB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srnb check failed");

`endif

// File: hdl/srnb_pkg.sv
package srnb_pkg;

  localparam int ROW_WORDS_DEF = 64;
  localparam int LINES_DEF     = 512;

  localparam int ROW_W   = 9;
  localparam int PX_W    = 10;
  localparam int HGT_W   = 6;
  localparam int WIDX_W  = 6;
  localparam int PIX_W   = 16;
  localparam int COL_W   = 9;
  localparam int OCOL_W  = 6;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam logic [PIX_W-1:0] FULL_MASK = 16'hFFFF;

  typedef struct packed {
    logic              func;
    logic [ROW_W-1:0]  scan_line;
    logic [PX_W-1:0]   pixel_x;
    logic [ROW_W-1:0]  sprite_top;
    logic [HGT_W-1:0]  sprite_height;
    logic [WIDX_W-1:0] word_index;
    logic [PIX_W-1:0]  tile_word;
    logic              last_word;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ROW_W-1:0]  write_row;
    logic [OCOL_W-1:0] write_column;
    logic [PIX_W-1:0]  write_data;
    logic [PIX_W-1:0]  keep_mask;
    logic              sprite_done;
    logic              last_result;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } res_pair_t;

endpackage

// File: hdl/srnb_calc.sv
module srnb_calc
  import srnb_pkg::*;
#(
  parameter int ROW_WORDS = ROW_WORDS_DEF,
  parameter int LINES     = LINES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  item_t            item,
  input  logic [PIX_W-1:0] bg_color,
  output res_pair_t        res
);

  logic [PIX_W-1:0] carry_word_r, carry_word_nxt;
  logic [COL_W-1:0] col, col_next;
  logic [1:0]       off;
  logic [3:0]       sh;
  logic [3:0]       sh_inv;
  logic [PIX_W-1:0] hmask, word, data0, keep0, tdata, new_carry;
  logic [ROW_W-1:0] row_diff;
  logic [ROW_W-1:0] span;
  logic             done, row_ok;

  function automatic result_t mk_result(input logic [COL_W-1:0] c,
                                        input logic [PIX_W-1:0] d,
                                        input logic [PIX_W-1:0] k,
                                        input logic             dn,
                                        input logic             lst,
                                        input logic             rok);
    result_t r;
    logic    ok;
    ok = rok && (32'(c) < ROW_WORDS);
    r.write_enable = ok;
    r.write_row    = item.scan_line;
    r.write_column = ok ? c[OCOL_W-1:0] : '0;
    r.write_data   = ok ? d : '0;
    r.keep_mask    = ok ? k : FULL_MASK;
    r.sprite_done  = dn;
    r.last_result  = lst;
    return r;
  endfunction

  always_comb begin
    col      = COL_W'(item.pixel_x[PX_W-1:2]) + COL_W'(item.word_index);
    col_next = col + COL_W'(1);
    off      = item.pixel_x[1:0];
    sh       = {off, 2'b00};
    sh_inv   = 4'(5'd16 - {1'b0, sh});
    hmask    = ~(FULL_MASK >> sh);
    word     = item.func ? bg_color : item.tile_word;
    row_ok   = 32'(item.scan_line) < LINES;

    row_diff = item.scan_line - item.sprite_top;
    span     = {1'b0, item.sprite_height, 2'b00} - ROW_W'(1);
    if ((item.scan_line < item.sprite_top) || (item.sprite_height == '0)) begin
      done = 1'b1;
    end else begin
      done = row_diff >= span;
    end

    new_carry = item.tile_word << sh_inv;
    if (item.word_index == '0) begin
      data0 = word >> sh;
      keep0 = hmask;
    end else begin
      data0 = item.func ? bg_color : (carry_word_r | (item.tile_word >> sh));
      keep0 = '0;
    end
    tdata = item.func ? (bg_color & hmask) : new_carry;

    carry_word_nxt = carry_word_r;
    if (off == 2'b00) begin
      res.first  = mk_result(col, word, '0, done, 1'b1, row_ok);
      res.second = mk_result(col_next, tdata, ~hmask, done, 1'b1, row_ok);
      res.two    = 1'b0;
    end else begin
      res.first  = mk_result(col, data0, keep0, item.last_word ? 1'b0 : done,
                             ~item.last_word, row_ok);
      res.second = mk_result(col_next, tdata, ~hmask, done, 1'b1, row_ok);
      res.two    = item.last_word;
      if (advance && !item.func) begin
        carry_word_nxt = new_carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_word_r <= '0;
    end else begin
      carry_word_r <= carry_word_nxt;
    end
  end

endmodule

// File: hdl/srnb_outq.sv
module srnb_outq
  import srnb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      src_valid,
  input  res_pair_t res,
  input  logic      out_ready,
  output logic      load_ok,
  output logic      out_valid,
  output result_t   out_res
);

  logic    out_valid_r, out_valid_nxt;
  logic    pend_r, pend_nxt;
  result_t out_r, out_nxt;
  result_t pend_data_r, pend_data_nxt;

  assign load_ok   = !out_valid_r || (out_ready && !pend_r);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    pend_data_nxt = pend_data_r;
    if (src_valid && load_ok) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res.first;
      pend_nxt      = res.two;
      pend_data_nxt = res.second;
    end else if (out_valid_r && out_ready) begin
      if (pend_r) begin
        out_nxt  = pend_data_r;
        pend_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    pend_data_r <= pend_data_nxt;
  end

endmodule

// File: hdl/sprite_row_nibble_blitter.sv
// Sprite row blitter: accepts one word of four packed pixels per cycle while
// in_tready is high, and returns masked line-buffer writes through an input
// register and an output register. A word gives one write; a word with a
// nonzero pixel offset that is also the last of its row gives a second,
// trailing write, and the next word is held in the input register until both
// writes are taken. The output register pair (current and pending write)
// holds the trailing write. The user must write the erase color on cfg_wdata
// only while the block is idle; the block itself does not enforce it.
`include "sprite_row_nibble_blitter_assert.svh"

module sprite_row_nibble_blitter
  import srnb_pkg::*;
#(
  parameter int ROW_WORDS = ROW_WORDS_DEF,
  parameter int LINES     = LINES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // scan_line, pixel_x, sprite_top, sprite_height, word_index, tile_word
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // write_row, write_column, write_data, keep_mask, sprite_done
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // write_enable
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [PIX_W-1:0]       cfg_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_r, s1_nxt;
  logic [PIX_W-1:0] bg_color_r, bg_color_nxt;
  logic             load_ok, advance, accept;
  res_pair_t        res;
  result_t          out_res;

  assign advance   = s1_valid_r && load_ok;
  assign in_tready = !s1_valid_r || load_ok;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    bg_color_nxt = cfg_we ? cfg_wdata : bg_color_r;
    if (accept) begin
      s1_valid_nxt         = 1'b1;
      s1_nxt.func          = in_tuser;
      s1_nxt.scan_line     = in_tdata[8:0];
      s1_nxt.pixel_x       = in_tdata[18:9];
      s1_nxt.sprite_top    = in_tdata[27:19];
      s1_nxt.sprite_height = in_tdata[33:28];
      s1_nxt.word_index    = in_tdata[39:34];
      s1_nxt.tile_word     = in_tdata[55:40];
      s1_nxt.last_word     = in_tlast;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      bg_color_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      bg_color_r <= bg_color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  srnb_calc #(
    .ROW_WORDS (ROW_WORDS),
    .LINES     (LINES)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (s1_r),
    .bg_color (bg_color_r),
    .res      (res)
  );

  srnb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (s1_valid_r),
    .res       (res),
    .out_ready (out_tready),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.sprite_done, out_res.keep_mask, out_res.write_data,
                      out_res.write_column, out_res.write_row};
  assign out_tuser = out_res.write_enable;
  assign out_tlast = out_res.last_result;

  `SRNB_ASSERT_IMP(a_done_on_last, out_tvalid && !out_tlast, !out_tdata[47])
  `SRNB_ASSERT_IMP(a_off_masked, out_tvalid && !out_tuser,
                   (out_tdata[46:31] == FULL_MASK) && (out_tdata[30:15] == '0))
  `SRNB_ASSERT_NXT(a_trail_follows, out_tvalid && out_tready && !out_tlast, out_tvalid)
  `SRNB_ASSERT_IMP(a_stall_holds_item, !in_tready, s1_valid_r && !load_ok)

endmodule
